>>> design/arrg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arrg_pkg
// Shared types and constants of the acknowledge/retry rule gate.
// ----------------------------------------------------------------------------
package arrg_pkg;

   localparam int QueueDepth      = 16;
   localparam int MaxRules        = 16;
   localparam int AckTimeoutTicks = 4;
   localparam int MaxRetries      = 3;
   localparam int OutLimit        = 16;
   localparam int SlotBits        = $clog2(QueueDepth);
   localparam int CntBits         = $clog2(QueueDepth + 1);
   localparam int RuleBits        = 4;

   localparam logic [1:0] OP_EVENT = 2'd0;
   localparam logic [1:0] OP_ACK   = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] KIND_SEND  = 2'd0;
   localparam logic [1:0] KIND_ABORT = 2'd1;
   localparam logic [1:0] KIND_ACK   = 2'd2;

   localparam logic [1:0] CSR_RULE_COUNT = 2'd0;
   localparam logic [1:0] CSR_DISABLED   = 2'd1;
   localparam logic [1:0] CSR_LIMITS_LO  = 2'd2;
   localparam logic [1:0] CSR_LIMITS_HI  = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  rule_id;
      logic [15:0] item_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] evt_id;
      logic [7:0]  rule_num;
      logic [3:0]  try_count;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVENT,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic do_event;  // gate and enqueue an event
      logic tick;      // advance time
      logic scan_step; // process entry at scan index
      logic shift_step;// move one entry down over the removed one
      logic emit_take; // result taken by output register
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic       op_event;
      logic       op_ack;
      logic       op_tick;
      logic       scan_done;  // index at fill, limit reached, ack matched or no scan
      logic       scan_hit;   // current entry produces a result
      logic       scan_remove;// and it is removed
      logic       shift_done;
      logic       event_emit; // event produced a result
   } sts_type;

endpackage
`default_nettype wire

>>> design/arrg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arrg_ctrl
// Sequencer: one request at a time, slot by slot scan, shift on removal.
// ----------------------------------------------------------------------------
module arrg_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              out_busy,
   input  wire arrg_pkg::sts_type sts,
   output arrg_pkg::ctl_type      ctl
);

   arrg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arrg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arrg_pkg::ST_IDLE: begin
            if (req_valid) state_in = arrg_pkg::ST_EVENT;
         end
         arrg_pkg::ST_EVENT: begin
            if (sts.op_event) begin
               if (!sts.event_emit) state_in = arrg_pkg::ST_IDLE;
               else if (!out_busy) state_in = arrg_pkg::ST_IDLE;
            end else begin
               state_in = arrg_pkg::ST_SCAN;
            end
         end
         arrg_pkg::ST_SCAN: begin
            if (sts.scan_done) state_in = arrg_pkg::ST_IDLE;
            else if (sts.scan_hit && !out_busy) begin
               state_in = sts.scan_remove ? arrg_pkg::ST_SHIFT : arrg_pkg::ST_SCAN;
            end
         end
         arrg_pkg::ST_SHIFT: begin
            if (sts.shift_done) state_in = sts.op_ack ? arrg_pkg::ST_IDLE
                                                      : arrg_pkg::ST_SCAN;
         end
         default: state_in = arrg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         arrg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         arrg_pkg::ST_EVENT: begin
            if (sts.op_event) begin
               ctl.do_event  = !sts.event_emit || !out_busy;
               ctl.emit_take = sts.event_emit && !out_busy;
            end else begin
               ctl.tick = sts.op_tick;
            end
         end
         arrg_pkg::ST_SCAN: begin
            if (!sts.scan_done) begin
               ctl.scan_step = !sts.scan_hit || !out_busy;
               ctl.emit_take = sts.scan_hit && !out_busy;
            end
         end
         arrg_pkg::ST_SHIFT: ctl.shift_step = 1'b1;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

>>> design/arrg_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arrg_dp
// Datapath: rule table, time, slot queue and result formation.
// ----------------------------------------------------------------------------
module arrg_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire arrg_pkg::req_type req_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [63:0]       csr_data,
   input  wire arrg_pkg::ctl_type ctl,
   output arrg_pkg::sts_type      sts,
   output arrg_pkg::rsp_type      res
);

   localparam int SB = arrg_pkg::SlotBits;
   localparam int CB = arrg_pkg::CntBits;
   localparam int RB = arrg_pkg::RuleBits;

   logic [4:0]  rule_count_ff;
   logic [15:0] disabled_ff;
   logic [63:0] lim_lo_ff, lim_hi_ff;
   logic [31:0] now_ff;
   logic [31:0] fire_time_ff [arrg_pkg::MaxRules];
   logic [arrg_pkg::MaxRules-1:0] fired_ff;
   logic [15:0] next_id_ff;
   arrg_pkg::req_type req_ff;

   logic [15:0] s_id_ff   [arrg_pkg::QueueDepth];
   logic [RB-1:0] s_rule_ff [arrg_pkg::QueueDepth];
   logic [3:0]  s_tries_ff [arrg_pkg::QueueDepth];
   logic [31:0] s_time_ff  [arrg_pkg::QueueDepth];
   logic [CB-1:0] fill_ff;
   logic [CB-1:0] idx_ff;
   logic [CB-1:0] outs_ff;
   logic          matched_ff;
   // after a shift the scan resumes at the removed slot
   logic [CB-1:0] resume_ff;

   // event gating
   logic [RB-1:0] rid;
   logic [7:0]    lim;
   logic [4:0]    eff;
   logic          known, blocked, full;
   logic [31:0]   since;
   always_comb begin
      rid   = req_ff.rule_id[RB-1:0];
      eff   = (rule_count_ff > 5'(arrg_pkg::MaxRules)) ? 5'(arrg_pkg::MaxRules)
                                                       : rule_count_ff;
      known = {1'b0, req_ff.rule_id} < {4'd0, eff};
      lim   = rid[3] ? lim_hi_ff[{rid[2:0], 3'b000} +: 8] : lim_lo_ff[{rid[2:0], 3'b000} +: 8];
      since = now_ff - fire_time_ff[rid];
      full  = fill_ff >= CB'(arrg_pkg::QueueDepth);
      blocked = disabled_ff[rid] || (lim != 8'd0 && fired_ff[rid] && since < {24'd0, lim})
                || full;
   end

   // scan of the current slot
   logic [SB-1:0] ix;
   logic          in_range, timed_out, hit, remove, limit_hit, ack_match;
   logic [31:0]   age;
   always_comb begin
      ix        = idx_ff[SB-1:0];
      in_range  = idx_ff < fill_ff;
      age       = now_ff - s_time_ff[ix];
      timed_out = age >= 32'(arrg_pkg::AckTimeoutTicks);
      ack_match = s_id_ff[ix] == req_ff.item_id;
      limit_hit = outs_ff >= CB'(arrg_pkg::OutLimit);
      if (req_ff.operation == arrg_pkg::OP_ACK) begin
         hit    = in_range && ack_match;
         remove = hit;
      end else begin
         hit    = in_range && timed_out;
         remove = s_tries_ff[ix] > 4'(arrg_pkg::MaxRetries);
      end
   end

   always_comb begin
      sts.op_event    = req_ff.operation == arrg_pkg::OP_EVENT;
      sts.op_ack      = req_ff.operation == arrg_pkg::OP_ACK;
      sts.op_tick     = req_ff.operation == arrg_pkg::OP_TICK;
      sts.scan_done   = !in_range || limit_hit || matched_ff
                        || !(sts.op_ack || sts.op_tick);
      sts.scan_hit    = hit;
      sts.scan_remove = remove;
      sts.shift_done  = idx_ff + CB'(1) >= fill_ff;
      sts.event_emit  = known;
   end

   // result formed combinationally; last decided from remaining work
   logic more;
   always_comb begin
      res  = '0;
      more = 1'b0;
      if (sts.op_event) begin
         res.kind      = blocked ? arrg_pkg::KIND_ABORT : arrg_pkg::KIND_SEND;
         res.evt_id    = blocked ? req_ff.item_id : next_id_ff;
         res.rule_num  = req_ff.rule_id;
         res.try_count = blocked ? 4'd0 : 4'd1;
         res.last      = 1'b1;
      end else begin
         res.kind      = sts.op_ack ? arrg_pkg::KIND_ACK
                       : (remove ? arrg_pkg::KIND_ABORT : arrg_pkg::KIND_SEND);
         res.evt_id    = s_id_ff[ix];
         res.rule_num  = {{(8-RB){1'b0}}, s_rule_ff[ix]};
         res.try_count = (sts.op_tick && !remove) ? s_tries_ff[ix] + 4'd1 : s_tries_ff[ix];
         // any further timed-out entry after this one?
         for (int j = 0; j < arrg_pkg::QueueDepth; j++) begin
            if (CB'(j) > idx_ff && CB'(j) < fill_ff
                && (now_ff - s_time_ff[j]) >= 32'(arrg_pkg::AckTimeoutTicks))
               more = 1'b1;
         end
         res.last = sts.op_ack || !more || (outs_ff + CB'(1) >= CB'(arrg_pkg::OutLimit));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         disabled_ff   <= '0;
         lim_lo_ff     <= '0;
         lim_hi_ff     <= '0;
         now_ff        <= '0;
         fired_ff      <= '0;
         next_id_ff    <= '0;
         fill_ff       <= '0;
         idx_ff        <= '0;
         outs_ff       <= '0;
         matched_ff    <= 1'b0;
         resume_ff     <= '0;
         for (int r = 0; r < arrg_pkg::MaxRules; r++) fire_time_ff[r] <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               arrg_pkg::CSR_RULE_COUNT: rule_count_ff <= csr_data[4:0];
               arrg_pkg::CSR_DISABLED:   disabled_ff   <= csr_data[15:0];
               arrg_pkg::CSR_LIMITS_LO:  lim_lo_ff     <= csr_data;
               arrg_pkg::CSR_LIMITS_HI:  lim_hi_ff     <= csr_data;
               default: ;
            endcase
         end
         if (ctl.load) begin
            req_ff     <= req_data;
            idx_ff     <= '0;
            outs_ff    <= '0;
            matched_ff <= 1'b0;
         end
         if (ctl.tick) now_ff <= now_ff + 32'd1;
         if (ctl.do_event && known && !blocked) begin
            s_id_ff[fill_ff[SB-1:0]]    <= next_id_ff;
            s_rule_ff[fill_ff[SB-1:0]]  <= rid;
            s_tries_ff[fill_ff[SB-1:0]] <= 4'd1;
            s_time_ff[fill_ff[SB-1:0]]  <= now_ff;
            fire_time_ff[rid]           <= now_ff;
            fired_ff[rid]               <= 1'b1;
            next_id_ff                  <= next_id_ff + 16'd1;
            fill_ff                     <= fill_ff + CB'(1);
         end
         if (ctl.scan_step) begin
            if (hit) outs_ff <= outs_ff + CB'(1);
            if (hit && sts.op_ack) matched_ff <= 1'b1;
            if (hit && sts.op_tick && !remove) begin
               s_tries_ff[ix] <= s_tries_ff[ix] + 4'd1;
               s_time_ff[ix]  <= now_ff;
               fire_time_ff[s_rule_ff[ix]] <= now_ff;
               fired_ff[s_rule_ff[ix]]     <= 1'b1;
            end
            if (hit && remove) resume_ff <= idx_ff;
            if (!(hit && remove)) idx_ff <= idx_ff + CB'(1);
         end
         if (ctl.shift_step) begin
            if (sts.shift_done) begin
               fill_ff <= fill_ff - CB'(1);
               idx_ff  <= resume_ff;
            end else begin
               s_id_ff[ix]    <= s_id_ff[ix + SB'(1)];
               s_rule_ff[ix]  <= s_rule_ff[ix + SB'(1)];
               s_tries_ff[ix] <= s_tries_ff[ix + SB'(1)];
               s_time_ff[ix]  <= s_time_ff[ix + SB'(1)];
               idx_ff         <= idx_ff + CB'(1);
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CB'(arrg_pkg::QueueDepth)) else $error("fill over depth");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.do_event, ctl.scan_step, ctl.shift_step, ctl.tick}))
      else $error("overlapping commands");
   a_tick_time: assert property (@(posedge clock) disable iff (reset)
      ctl.tick |=> now_ff == $past(now_ff) + 32'd1) else $error("time step");
`endif

endmodule
`default_nettype wire

>>> design/ack_retry_rule_gate_core.sv
`default_nettype none
// Timing: a request is captured in the request register; an event for a known rule then
//   has its result registered in the output register, while ack and tick scan one queue
//   slot a cycle, unless the result side stalls or a removal shifts the queue.
// Throughput: one request at a time; each removal shifts the later entries down slot by
//   slot, and a stalled result side holds the request.
// Reset: synchronous, active high; clears time, rule history, queue fill and ids.
// ----------------------------------------------------------------------------
// ack_retry_rule_gate_core
// Rule event gate with acknowledge tracking and timed retry.
// ----------------------------------------------------------------------------
module ack_retry_rule_gate_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire arrg_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output arrg_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [63:0]       csr_data
);

   arrg_pkg::ctl_type ctl;
   arrg_pkg::sts_type sts;
   arrg_pkg::rsp_type res;
   logic              out_busy;

   // output register: holds a result until taken
   logic              rsp_valid_ff;
   arrg_pkg::rsp_type rsp_data_ff;

   assign out_busy = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit_take) rsp_data_ff <= res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   arrg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .out_busy (out_busy),
      .sts      (sts),
      .ctl      (ctl)
   );

   arrg_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .ctl      (ctl),
      .sts      (sts),
      .res      (res)
   );

endmodule
`default_nettype wire
